// ===== hw/rtl/hrlp_pkg.sv =====
// Shared types, constants and helper functions for the HTTP request line parser.
`default_nettype none

package hrlp_pkg;

  // Sizing of the URI and message counters.
  localparam int unsigned UriMax  = 256;
  localparam int unsigned MsgMax  = 4096;
  localparam int unsigned UriCntW = $clog2(UriMax + 1);
  localparam int unsigned PosW    = $clog2(MsgMax);

  // Method codes reported in the verdict.
  localparam logic [1:0] MethGet  = 2'd0;
  localparam logic [1:0] MethHead = 2'd1;
  localparam logic [1:0] MethPost = 2'd2;

  // Result kinds.
  localparam logic KindUri     = 1'b0;
  localparam logic KindVerdict = 1'b1;

  // Characters the parser looks for.
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChNul   = 8'h00;

  // Method tokens as they collect in the shift register.
  localparam logic [31:0] TokGet  = 32'h0047_4554;
  localparam logic [31:0] TokHead = 32'h4845_4144;
  localparam logic [31:0] TokPost = 32'h504F_5354;

  // The three bytes of a blank line that come before its final LF: CR LF CR.
  localparam logic [23:0] WinCrLfCr = 24'h0D_0A0D;

  // Length of the protocol prefix "HTTP/".
  localparam logic [2:0] ProtoLen = 3'd5;

  // Parser phases.
  typedef enum logic [3:0] {
    PhMethod,
    PhUri,
    PhProto,
    PhMajor,
    PhMinor,
    PhCr,
    PhDone,
    PhCut,
    PhBad
  } phase_e;

  // One input beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_beat_t;

  // One result beat.
  typedef struct packed {
    logic               kind;
    logic [7:0]         uri_byte;
    logic               valid_res;
    logic [1:0]         method;
    logic [UriCntW-1:0] uri_length;
    logic               has_entity;
    logic [PosW-1:0]    entity_offset;
  } res_beat_t;

  // Handshake between the pipeline stages and the parser core.
  typedef struct packed {
    logic step;
    logic emit;
  } step_ctrl_t;

  // Whitespace: space, HT, LF, VT, FF and CR.
  function automatic logic is_ws(logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // Expected character of the "HTTP/" prefix at a given position.
  function automatic logic [7:0] proto_char(logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      3'd4:    c = 8'h2F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hrlp_intf.sv =====
// Valid/ready channel interfaces for request bytes and parser results.
`default_nettype none

interface hrlp_byte_if;
  import hrlp_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hrlp_res_if;
  import hrlp_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [7:0]         uri_byte;
  logic               valid_res;
  logic [1:0]         method;
  logic [UriCntW-1:0] uri_length;
  logic               has_entity;
  logic [PosW-1:0]    entity_offset;

  modport source (output valid, output kind, output uri_byte, output valid_res,
                  output method, output uri_length, output has_entity,
                  output entity_offset, input ready);
  modport sink   (input valid, input kind, input uri_byte, input valid_res,
                  input method, input uri_length, input has_entity,
                  input entity_offset, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hrlp_in_stage.sv =====
// Input register stage: holds one request byte until the parser core takes it.
`default_nettype none

module hrlp_in_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire hrlp_pkg::byte_beat_t in_beat_i,
  output logic                     in_ready_o,
  input  wire logic                out_free_i,
  output logic                     step_o,
  output hrlp_pkg::byte_beat_t     beat_o
);
  import hrlp_pkg::*;

  logic       valid_q;
  byte_beat_t beat_q;

  // The held byte is parsed whenever the result register can take its result.
  assign step_o     = valid_q && out_free_i;
  assign in_ready_o = !valid_q || step_o;
  assign beat_o     = beat_q;

  // Valid flag of the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload, loaded on every accepted beat.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      beat_q <= in_beat_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hrlp_core.sv =====
// Parser core: request line state machine, counters and blank line search.
`default_nettype none

module hrlp_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire hrlp_pkg::byte_beat_t beat_i,
  output logic                      emit_o,
  output hrlp_pkg::res_beat_t       res_o
);
  import hrlp_pkg::*;

  localparam logic [PosW-1:0]    PosMax   = PosW'(MsgMax - 1);
  localparam logic [UriCntW-1:0] UriLimit = UriCntW'(UriMax);

  phase_e             phase_q, phase_d, phase_u;
  logic [31:0]        chars_q, chars_d, chars_u;
  logic [2:0]         mcnt_q, mcnt_d, mcnt_u;
  logic [UriCntW-1:0] uri_q, uri_d, uri_u;
  logic [PosW-1:0]    pos_q, pos_d, pos_u;
  logic [23:0]        recent_q, recent_d, recent_u;
  logic               blank_q, blank_d, blank_u;
  logic [PosW-1:0]    bpos_q, bpos_d, bpos_u;
  logic [1:0]         meth_q, meth_d, meth_u;

  logic [7:0] b;
  logic       ws;
  logic       search_on;
  logic       ok;
  logic       ent;

  assign b         = beat_i.data_byte;
  assign ws        = is_ws(b);
  assign search_on = (phase_q != PhCut) && (phase_q != PhBad);

  // Next state: effect of the current byte, then a return to reset on the last byte.
  always_comb begin
    phase_u  = phase_q;
    chars_u  = chars_q;
    mcnt_u   = mcnt_q;
    uri_u    = uri_q;
    recent_u = recent_q;
    blank_u  = blank_q;
    bpos_u   = bpos_q;
    meth_u   = meth_q;

    // Blank line search runs until the request is cut off or found bad.
    if (search_on) begin
      if ((recent_q == WinCrLfCr) && (b == ChLf) && !blank_q && (pos_q < PosMax)) begin
        blank_u = 1'b1;
        bpos_u  = pos_q - PosW'(3);
      end
      recent_u = {recent_q[15:0], b};
    end

    case (phase_q)
      PhMethod: begin
        if (b == ChSpace) begin
          if ((mcnt_q == 3'd3) && (chars_q == TokGet)) begin
            meth_u  = MethGet;
            phase_u = PhUri;
          end else if ((mcnt_q == 3'd4) && (chars_q == TokHead)) begin
            meth_u  = MethHead;
            phase_u = PhUri;
          end else if ((mcnt_q == 3'd4) && (chars_q == TokPost)) begin
            meth_u  = MethPost;
            phase_u = PhUri;
          end else begin
            phase_u = PhBad;
          end
        end else if ((b == ChNul) || ws || (mcnt_q >= 3'd4)) begin
          phase_u = PhBad;
        end else begin
          chars_u = {chars_q[23:0], b};
          mcnt_u  = mcnt_q + 3'd1;
        end
      end
      PhUri: begin
        if (b == ChSpace) begin
          phase_u = PhProto;
          mcnt_u  = 3'd0;
        end else if ((b == ChNul) || ws || (uri_q >= UriLimit)) begin
          phase_u = PhBad;
        end else begin
          uri_u = uri_q + UriCntW'(1);
        end
      end
      PhProto: begin
        if ((mcnt_q < ProtoLen) && (b == proto_char(mcnt_q))) begin
          mcnt_u = mcnt_q + 3'd1;
          if (mcnt_q == ProtoLen - 3'd1) begin
            phase_u = PhMajor;
          end
        end else begin
          phase_u = PhBad;
        end
      end
      PhMajor: begin
        if (b == ChDot) begin
          phase_u = PhMinor;
        end else if (!is_digit(b)) begin
          phase_u = PhBad;
        end
      end
      PhMinor: begin
        if (b == ChCr) begin
          phase_u = PhCr;
        end else if (!is_digit(b)) begin
          phase_u = PhBad;
        end
      end
      PhCr: begin
        phase_u = (b == ChLf) ? PhDone : PhBad;
      end
      PhDone: begin
        if (b == ChNul) begin
          phase_u = PhCut;
        end
      end
      PhCut: begin
        phase_u = PhCut;
      end
      default: begin
        phase_u = PhBad;
      end
    endcase

    // Byte position saturates at the top of the message window.
    pos_u = (pos_q < PosMax) ? pos_q + PosW'(1) : pos_q;

    if (beat_i.last_byte) begin
      phase_d  = PhMethod;
      chars_d  = '0;
      mcnt_d   = '0;
      uri_d    = '0;
      pos_d    = '0;
      recent_d = '0;
      blank_d  = 1'b0;
      bpos_d   = '0;
      meth_d   = MethGet;
    end else begin
      phase_d  = phase_u;
      chars_d  = chars_u;
      mcnt_d   = mcnt_u;
      uri_d    = uri_u;
      pos_d    = pos_u;
      recent_d = recent_u;
      blank_d  = blank_u;
      bpos_d   = bpos_u;
      meth_d   = meth_u;
    end
  end

  // Outputs: a URI byte pass-through, or the verdict on the last byte.
  always_comb begin
    ok  = (phase_u == PhDone) || (phase_u == PhCut);
    ent = ok && (meth_u == MethPost) && blank_u;
    res_o = '0;
    if (beat_i.last_byte) begin
      emit_o              = 1'b1;
      res_o.kind          = KindVerdict;
      res_o.valid_res     = ok;
      res_o.method        = ok ? meth_u : MethGet;
      res_o.uri_length    = ok ? uri_u : '0;
      res_o.has_entity    = ent;
      res_o.entity_offset = ent ? bpos_u : '0;
    end else begin
      emit_o         = (phase_q == PhUri) && (b != ChNul) && !ws && (uri_q < UriLimit);
      res_o.kind     = KindUri;
      res_o.uri_byte = b;
    end
  end

  // Parser state, advanced once per parsed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhMethod;
      chars_q  <= '0;
      mcnt_q   <= '0;
      uri_q    <= '0;
      pos_q    <= '0;
      recent_q <= '0;
      blank_q  <= 1'b0;
      bpos_q   <= '0;
      meth_q   <= MethGet;
    end else if (step_i) begin
      phase_q  <= phase_d;
      chars_q  <= chars_d;
      mcnt_q   <= mcnt_d;
      uri_q    <= uri_d;
      pos_q    <= pos_d;
      recent_q <= recent_d;
      blank_q  <= blank_d;
      bpos_q   <= bpos_d;
      meth_q   <= meth_d;
    end
  end

  // The URI count never passes its limit.
  a_uri_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uri_q <= UriLimit)
    else $error("URI count beyond its limit");

  // A last byte returns the parser to the start of a new message.
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && beat_i.last_byte |=> (phase_q == PhMethod) && (pos_q == '0) && !blank_q)
    else $error("Parser state not cleared after the last byte");

  // A URI byte is only passed on while the URI is being read.
  a_emit_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o && !beat_i.last_byte |-> (phase_q == PhUri))
    else $error("URI byte emitted outside the URI");

  // A recorded blank line always lies behind the current position.
  a_blank_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blank_q |-> ({1'b0, bpos_q} + (PosW + 1)'(3) < {1'b0, pos_q}))
    else $error("Blank line position not behind the byte position");

endmodule

`default_nettype wire

// ===== hw/rtl/hrlp_out_stage.sv =====
// Result register stage: holds one result beat until the receiver takes it.
`default_nettype none

module hrlp_out_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire hrlp_pkg::step_ctrl_t ctrl_i,
  input  wire hrlp_pkg::res_beat_t  res_i,
  output logic                      out_free_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output hrlp_pkg::res_beat_t       res_o
);
  import hrlp_pkg::*;

  logic      valid_q;
  res_beat_t res_q;

  // The register frees up in the same cycle the receiver takes its beat.
  assign out_free_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  // Valid flag of the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_free_o) begin
      valid_q <= ctrl_i.step && ctrl_i.emit;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.step && ctrl_i.emit) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/http_request_line_parser.sv =====
// Top level of the HTTP request line parser.
//
// The block takes a request message one byte per beat on req_i (data_byte,
// last_byte) and checks its request line: GET, HEAD or POST, a space, a URI,
// a space, then HTTP/ digits . digits CR LF. Each URI byte goes out on res_o
// as a beat of kind 0. The beat carrying last_byte gives one verdict beat of
// kind 1 with validity, method, URI length and, for POST, the offset of the
// first CR LF CR LF. After that beat the parser starts on a new message.
// Both channels use a valid/ready handshake.
//
// A byte is held in the input register and its result in the result
// register. Throughput: one byte per cycle while the receiver keeps up; the
// byte state machine closes its loop between the input and result registers.
// When the receiver stalls, the result register holds its beat, one more byte
// waits in the input register, and req_i.ready then drops until res_o drains.
// Reset empties both registers and returns the parser to the method field;
// there is no clearing pass.
`default_nettype none

module http_request_line_parser (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hrlp_byte_if.sink   req_i,
  hrlp_res_if.source  res_o
);
  import hrlp_pkg::*;

  byte_beat_t in_beat;
  byte_beat_t core_beat;
  res_beat_t  core_res;
  res_beat_t  out_res;
  step_ctrl_t ctrl;
  logic       in_ready;
  logic       out_free;
  logic       out_valid;
  logic       step;
  logic       emit;

  assign in_beat.data_byte = req_i.data_byte;
  assign in_beat.last_byte = req_i.last_byte;
  assign req_i.ready       = in_ready;

  // Input register stage.
  hrlp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_beat_i  (in_beat),
    .in_ready_o (in_ready),
    .out_free_i (out_free),
    .step_o     (step),
    .beat_o     (core_beat)
  );

  // Request line parser.
  hrlp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .beat_i (core_beat),
    .emit_o (emit),
    .res_o  (core_res)
  );

  assign ctrl.step = step;
  assign ctrl.emit = emit;

  // Result register stage.
  hrlp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .res_i       (core_res),
    .out_free_o  (out_free),
    .out_valid_o (out_valid),
    .out_ready_i (res_o.ready),
    .res_o       (out_res)
  );

  assign res_o.valid         = out_valid;
  assign res_o.kind          = out_res.kind;
  assign res_o.uri_byte      = out_res.uri_byte;
  assign res_o.valid_res     = out_res.valid_res;
  assign res_o.method        = out_res.method;
  assign res_o.uri_length    = out_res.uri_length;
  assign res_o.has_entity    = out_res.has_entity;
  assign res_o.entity_offset = out_res.entity_offset;

endmodule

`default_nettype wire
